// ===== src/ccsa_pkg.sv =====
// Package for the conditional count, sum and average block.
// Holds widths, compare codes, the group totals record and the back-end states.
// No dependencies.
`timescale 1ns / 1ps

package ccsa_pkg;

   // Field widths.
   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = 32;
   localparam int SUM_BITS   = 64;
   localparam int MEAN_BITS  = 32;
   localparam int MODE_BITS  = 3;

   // Packed stream widths.
   localparam int REQ_DATA_BITS = 2 * VALUE_BITS;
   localparam int RSP_DATA_BITS = COUNT_BITS + SUM_BITS + MEAN_BITS;
   localparam int RSP_USER_BITS = 2;

   // Queue of finished group totals between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QFILL_BITS  = $clog2(QUEUE_DEPTH + 1);

   // Divider step counter: one quotient bit per cycle.
   localparam int DIV_STEP_BITS = $clog2(SUM_BITS);

   // Magnitude limits of the mean, held at the width of the quotient.
   localparam logic [SUM_BITS-1:0] MEAN_POS_LIMIT =
      {{(SUM_BITS-MEAN_BITS+1){1'b0}}, {(MEAN_BITS-1){1'b1}}};
   localparam logic [SUM_BITS-1:0] MEAN_NEG_LIMIT =
      {{(SUM_BITS-MEAN_BITS){1'b0}}, 1'b1, {(MEAN_BITS-1){1'b0}}};
   localparam logic [MEAN_BITS-1:0] MEAN_MAX = {1'b0, {(MEAN_BITS-1){1'b1}}};
   localparam logic [MEAN_BITS-1:0] MEAN_MIN = {1'b1, {(MEAN_BITS-1){1'b0}}};

   // Compare codes of the mode register.
   typedef enum logic [MODE_BITS-1:0] {
      CMP_GT = 3'd0,
      CMP_GE = 3'd1,
      CMP_LT = 3'd2,
      CMP_LE = 3'd3,
      CMP_EQ = 3'd4,
      CMP_NE = 3'd5
   } compare_mode_type;

   // Totals of one finished group.
   typedef struct packed {
      logic [COUNT_BITS-1:0]      count;
      logic signed [SUM_BITS-1:0] sum;
      logic                       overflow;
   } totals_type;

   // Back-end sequencer states.
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_FINISH
   } back_state_type;

endpackage

// ===== src/ccsa_front.sv =====
// Front end: accepts rows, applies the compare and updates the running totals.
// Pushes the totals of each finished group into the queue. Uses ccsa_pkg.
`timescale 1ns / 1ps

module ccsa_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [ccsa_pkg::MODE_BITS-1:0]     csr_wr_data,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ccsa_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                               req_tuser,
   input  logic                               req_tlast,
   output logic                               push_valid,
   output ccsa_pkg::totals_type               push_data,
   input  logic                               push_ready
);
   import ccsa_pkg::*;

   logic [MODE_BITS-1:0]       mode_ff;
   logic [COUNT_BITS-1:0]      count_ff, count_in;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic                       ovf_ff, ovf_in;

   logic signed [VALUE_BITS-1:0] row_value;
   logic signed [VALUE_BITS-1:0] row_threshold;
   logic                         accept;
   logic                         match;
   logic [COUNT_BITS-1:0]        count_base;
   logic signed [SUM_BITS-1:0]   sum_base;
   logic                         ovf_base;
   logic [SUM_BITS-1:0]          addend;
   logic [SUM_BITS:0]            wide_sum;

   // A word is taken only while the queue can hold a group end.
   assign req_tready = push_ready;
   assign accept     = req_tvalid && req_tready;

   assign row_value     = $signed(req_tdata[VALUE_BITS-1:0]);
   assign row_threshold = $signed(req_tdata[2*VALUE_BITS-1:VALUE_BITS]);

   // Comparison of value against threshold; unused codes act as greater.
   always_comb begin
      case (compare_mode_type'(mode_ff))
         CMP_GE:  match = row_value >= row_threshold;
         CMP_LT:  match = row_value <  row_threshold;
         CMP_LE:  match = row_value <= row_threshold;
         CMP_EQ:  match = row_value == row_threshold;
         CMP_NE:  match = row_value != row_threshold;
         default: match = row_value >  row_threshold;
      endcase
   end

   // Totals start from zero on the first row of a group.
   assign count_base = req_tuser ? '0 : count_ff;
   assign sum_base   = req_tuser ? '0 : sum_ff;
   assign ovf_base   = req_tuser ? 1'b0 : ovf_ff;

   assign addend   = {{(SUM_BITS-VALUE_BITS){row_value[VALUE_BITS-1]}}, row_value};
   assign wide_sum = {sum_base[SUM_BITS-1], sum_base} + {addend[SUM_BITS-1], addend};

   // Saturating count and sum update for a matching row.
   always_comb begin
      count_in = count_base;
      sum_in   = sum_base;
      ovf_in   = ovf_base;
      if (match) begin
         if (count_base != {COUNT_BITS{1'b1}}) begin
            count_in = count_base + 1'b1;
         end
         if (wide_sum[SUM_BITS] != wide_sum[SUM_BITS-1]) begin
            ovf_in = 1'b1;
            sum_in = wide_sum[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                        : {1'b0, {(SUM_BITS-1){1'b1}}};
         end else begin
            sum_in = wide_sum[SUM_BITS-1:0];
         end
      end
   end

   // The totals after the last row of a group go to the queue.
   assign push_valid         = accept && req_tlast;
   assign push_data.count    = count_in;
   assign push_data.sum      = sum_in;
   assign push_data.overflow = ovf_in;

   // Mode register and running totals.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_BITS'(CMP_GT);
         count_ff <= '0;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (accept) begin
            count_ff <= count_in;
            sum_ff   <= sum_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

endmodule

// ===== src/ccsa_queue.sv =====
// Short queue of finished group totals between the front and back ends.
// Uses ccsa_pkg for the totals record and the depth.
`timescale 1ns / 1ps

module ccsa_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  ccsa_pkg::totals_type push_data,
   output logic                 push_ready,
   output logic                 pop_valid,
   output ccsa_pkg::totals_type pop_data,
   input  logic                 pop_ready
);
   import ccsa_pkg::*;

   totals_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QFILL_BITS-1:0]   fill_ff, fill_in;
   logic                    do_push;
   logic                    do_pop;

   assign push_ready = fill_ff != QFILL_BITS'(QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer wrap and fill level.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/ccsa_back.sv =====
// Back end: divides the group sum by the count, one quotient bit per cycle,
// saturates the mean and holds the result word. Uses ccsa_pkg.
`timescale 1ns / 1ps

module ccsa_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               pop_valid,
   input  ccsa_pkg::totals_type               pop_data,
   output logic                               pop_ready,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ccsa_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [ccsa_pkg::RSP_USER_BITS-1:0] rsp_tuser
);
   import ccsa_pkg::*;

   back_state_type             state_ff, state_in;
   totals_type                 total_ff, total_in;
   logic                       neg_ff, neg_in;
   logic [SUM_BITS-1:0]        quot_ff, quot_in;
   logic [COUNT_BITS-1:0]      rem_ff, rem_in;
   logic [DIV_STEP_BITS-1:0]   step_ff, step_in;
   logic                       out_valid_ff, out_valid_in;
   logic [RSP_DATA_BITS-1:0]   out_data_ff, out_data_in;
   logic [RSP_USER_BITS-1:0]   out_user_ff, out_user_in;

   logic [COUNT_BITS:0]        rem_shift;
   logic [COUNT_BITS+1:0]      rem_diff;
   logic                       out_free;
   logic [MEAN_BITS-1:0]       mean;
   logic                       is_null;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign out_free   = !out_valid_ff || rsp_tready;

   // One restoring division step.
   assign rem_shift = {rem_ff, quot_ff[SUM_BITS-1]};
   assign rem_diff  = {1'b0, rem_shift} - {2'b00, total_ff.count};

   // Sign and range of the mean from the quotient magnitude.
   always_comb begin
      is_null = total_ff.count == '0;
      if (is_null) begin
         mean = '0;
      end else if (neg_ff) begin
         mean = (quot_ff > MEAN_NEG_LIMIT) ? MEAN_MIN : (~quot_ff[MEAN_BITS-1:0] + 1'b1);
      end else begin
         mean = (quot_ff > MEAN_POS_LIMIT) ? MEAN_MAX : quot_ff[MEAN_BITS-1:0];
      end
   end

   // Sequencer: load totals, divide unless the count is zero, then place the result word.
   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      neg_in       = neg_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      pop_ready    = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               total_in = pop_data;
               neg_in   = pop_data.sum[SUM_BITS-1];
               quot_in  = pop_data.sum[SUM_BITS-1] ? (~pop_data.sum + 1'b1) : pop_data.sum;
               rem_in   = '0;
               step_in  = '1;
               state_in = (pop_data.count == '0) ? BK_FINISH : BK_DIVIDE;
            end
         end
         BK_DIVIDE: begin
            if (!rem_diff[COUNT_BITS+1]) begin
               rem_in  = rem_diff[COUNT_BITS-1:0];
               quot_in = {quot_ff[SUM_BITS-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift[COUNT_BITS-1:0];
               quot_in = {quot_ff[SUM_BITS-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = BK_FINISH;
            end
         end
         BK_FINISH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = {mean, total_ff.sum, total_ff.count};
               out_user_in  = {total_ff.overflow, is_null};
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      total_ff    <= total_in;
      neg_ff      <= neg_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
   end

endmodule

// ===== src/conditional_count_sum_average.sv =====
// Top level of the conditional count, sum and average block.
// Instantiates ccsa_front, ccsa_queue and ccsa_back; uses ccsa_pkg.
//
//   Channel  Dir  Handshake          Payload
//   req      in   req_tvalid/tready  tdata: row_value, row_threshold;
//                                    tuser: first_of_group; tlast: last_of_group
//   rsp      out  rsp_tvalid/tready  tdata: match_total, value_total, mean_value;
//                                    tuser: mean_is_null, sum_overflowed
//   csr      in   csr_wr_en          csr_wr_data: compare_mode
//
// Rows are taken one per cycle while the queue has room; the compare and saturating update finish in that cycle.
// A group end takes the back end through one load, 64 divider steps and the placing of
// the result word; an empty group skips the divider.
// Two finished groups can wait in the queue; when it is full, req_tready drops.
// Reset clears the totals, the compare mode (greater), the queue and the result valid flag.
`timescale 1ns / 1ps

module conditional_count_sum_average (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration.
   input  logic                               csr_wr_en,
   input  logic [ccsa_pkg::MODE_BITS-1:0]     csr_wr_data,
   // Row words.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ccsa_pkg::REQ_DATA_BITS-1:0] req_tdata,  // row_value, row_threshold
   input  logic                               req_tuser,  // first_of_group
   input  logic                               req_tlast,  // last_of_group
   // Result words.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ccsa_pkg::RSP_DATA_BITS-1:0] rsp_tdata,  // match_total, value_total, mean_value
   output logic [ccsa_pkg::RSP_USER_BITS-1:0] rsp_tuser   // mean_is_null, sum_overflowed
);
   import ccsa_pkg::*;

   logic       push_valid;
   logic       push_ready;
   totals_type push_data;
   logic       pop_valid;
   logic       pop_ready;
   totals_type pop_data;

   // Row filter and running totals.
   ccsa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .push_valid  (push_valid),
      .push_data   (push_data),
      .push_ready  (push_ready)
   );

   // Finished group totals waiting for the divider.
   ccsa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   // Mean division and result word.
   ccsa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== tb/ccsa_checker.sv =====
// Checker for the conditional count, sum and average block.
// Watches the csr, req and rsp channels, predicts each result word and compares it.
// Depends on ccsa_pkg for widths and compare codes.
`timescale 1ns / 1ps

module ccsa_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [ccsa_pkg::MODE_BITS-1:0]     csr_wr_data,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [ccsa_pkg::REQ_DATA_BITS-1:0] req_tdata,  // row_value, row_threshold
   input  logic                               req_tuser,  // first_of_group
   input  logic                               req_tlast,  // last_of_group
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [ccsa_pkg::RSP_DATA_BITS-1:0] rsp_tdata,  // match_total, value_total, mean_value
   input  logic [ccsa_pkg::RSP_USER_BITS-1:0] rsp_tuser,  // mean_is_null, sum_overflowed
   output int                                 fail_count,
   output int                                 pending
);
   import ccsa_pkg::*;

   // One group result as the block should report it.
   typedef struct {
      logic [COUNT_BITS-1:0]       match_total;
      logic signed [SUM_BITS-1:0]  value_total;
      logic signed [MEAN_BITS-1:0] mean_value;
      logic                        mean_is_null;
      logic                        sum_overflowed;
   } group_result_type;

   // Shadow of the compare mode and the running group totals.
   logic [MODE_BITS-1:0]       mode_shadow;
   logic [COUNT_BITS-1:0]      match_count;
   logic signed [SUM_BITS-1:0] match_sum;
   logic                       overflow_seen;
   group_result_type           totals_due[$];

   initial fail_count = 0;

   function automatic logic row_matches(logic signed [VALUE_BITS-1:0] value,
                                        logic signed [VALUE_BITS-1:0] threshold);
      case (mode_shadow)
         CMP_GE:  return value >= threshold;
         CMP_LT:  return value < threshold;
         CMP_LE:  return value <= threshold;
         CMP_EQ:  return value == threshold;
         CMP_NE:  return value != threshold;
         // Greater, and the two unused codes behave like it.
         default: return value > threshold;
      endcase
   endfunction

   // Apply one row to the totals; a group end queues the expected result word.
   task automatic fold_row(logic signed [VALUE_BITS-1:0] value,
                           logic signed [VALUE_BITS-1:0] threshold,
                           logic first, logic last);
      logic signed [SUM_BITS:0] widened;
      longint                   quotient;
      group_result_type         result;
      if (first) begin
         match_count   = '0;
         match_sum     = '0;
         overflow_seen = 1'b0;
      end
      if (row_matches(value, threshold)) begin
         if (match_count != '1) match_count++;
         widened = {match_sum[SUM_BITS-1], match_sum} +
                   {{(SUM_BITS-VALUE_BITS+1){value[VALUE_BITS-1]}}, value};
         // The sum holds at the bound it would cross and the flag sticks.
         if (widened[SUM_BITS] != widened[SUM_BITS-1]) begin
            match_sum = widened[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                          : {1'b0, {(SUM_BITS-1){1'b1}}};
            overflow_seen = 1'b1;
         end else begin
            match_sum = widened[SUM_BITS-1:0];
         end
      end
      if (last) begin
         result.match_total    = match_count;
         result.value_total    = match_sum;
         result.sum_overflowed = overflow_seen;
         if (match_count == '0) begin
            result.mean_value   = '0;
            result.mean_is_null = 1'b1;
         end else begin
            quotient = longint'(match_sum) / longint'({32'd0, match_count});
            if (quotient > longint'(MEAN_MAX)) quotient = longint'(MEAN_MAX);
            if (quotient < -longint'({1'b0, MEAN_MIN})) quotient = -longint'({1'b0, MEAN_MIN});
            result.mean_value   = quotient[MEAN_BITS-1:0];
            result.mean_is_null = 1'b0;
         end
         totals_due.push_back(result);
      end
   endtask

   task automatic check_field(string field, longint want, longint got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      end
   endtask

   // Everything is sampled at the rising edge, before the block's own updates land.
   always @(posedge clock) begin
      group_result_type seen;
      group_result_type want;
      if (reset) begin
         mode_shadow   = CMP_GT;
         match_count   = '0;
         match_sum     = '0;
         overflow_seen = 1'b0;
         totals_due.delete();
         pending <= 0;
      end else begin
         // A row taken at this edge still sees the mode from before the edge.
         if (req_tvalid && req_tready)
            fold_row(req_tdata[VALUE_BITS-1:0], req_tdata[2*VALUE_BITS-1:VALUE_BITS],
                     req_tuser, req_tlast);
         if (csr_wr_en) mode_shadow = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            seen.match_total    = rsp_tdata[COUNT_BITS-1:0];
            seen.value_total    = rsp_tdata[COUNT_BITS +: SUM_BITS];
            seen.mean_value     = rsp_tdata[COUNT_BITS+SUM_BITS +: MEAN_BITS];
            seen.mean_is_null   = rsp_tuser[0];
            seen.sum_overflowed = rsp_tuser[1];
            if (totals_due.size() == 0) begin
               fail_count++;
               $display("%0t: result word with none expected, expected nothing actual %0d",
                        $time, seen.match_total);
            end else begin
               want = totals_due.pop_front();
               check_field("match_total", {32'd0, want.match_total},
                           {32'd0, seen.match_total});
               check_field("value_total", want.value_total, seen.value_total);
               check_field("mean_value", want.mean_value, seen.mean_value);
               check_field("mean_is_null", want.mean_is_null, seen.mean_is_null);
               check_field("sum_overflowed", want.sum_overflowed, seen.sum_overflowed);
            end
         end
         pending <= totals_due.size();
      end
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench for conditional_count_sum_average.
// Drives rows and compare modes, stalls the result side and gives the verdict.
// Depends on ccsa_pkg, the block under test and ccsa_checker.
`timescale 1ns / 1ps

module testbench;
   import ccsa_pkg::*;

   localparam logic [VALUE_BITS-1:0] VALUE_MAX     = 32'h7fff_ffff;
   localparam logic [VALUE_BITS-1:0] VALUE_MIN     = 32'h8000_0000;
   localparam int BACK_LATENCY  = 66;
   localparam int DRAIN_CYCLES  = BACK_LATENCY + 20;
   localparam int RANDOM_PHASES = 12;
   localparam int ROWS_PER_PHASE = 50;
   localparam int CYCLE_LIMIT   = 400000;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [MODE_BITS-1:0]     csr_wr_data;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;   // row_value, row_threshold
   logic                     req_tuser;   // first_of_group
   logic                     req_tlast;   // last_of_group
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // match_total, value_total, mean_value
   logic [RSP_USER_BITS-1:0] rsp_tuser;   // mean_is_null, sum_overflowed

   int fail_count;
   int pending;
   int cycle_count;
   int ready_hold;
   logic no_idle;

   conditional_count_sum_average u_top (.*);

   ccsa_checker u_checker (.*);

   // Clock and watchdog.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 4);
   endfunction

   // Result side: after each accepted word, hold tready low for a drawn number of cycles.
   always @(posedge clock) begin
      int hold;
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_hold <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         hold = draw_wait();
         rsp_tready <= (hold == 0);
         ready_hold <= hold;
      end else if (ready_hold != 0) begin
         rsp_tready <= (ready_hold == 1);
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Offer one row word after a drawn gap and wait until it is taken.
   task automatic send_row(logic [VALUE_BITS-1:0] value, logic [VALUE_BITS-1:0] threshold,
                           logic first, logic last);
      int gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {threshold, value};
      req_tuser  <= first;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // Wait until every result has arrived and the back end has had time to settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(logic [MODE_BITS-1:0] mode);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Values lean toward small numbers and the extremes so every compare outcome shows up.
   function automatic logic [VALUE_BITS-1:0] pick_value();
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return $urandom;
         4, 5:       return VALUE_BITS'(int'($urandom_range(0, 16)) - 8);
         6:          return $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
         default:    return $urandom_range(0, 1) ? VALUE_BITS'(0) : '1;
      endcase
   endfunction

   task automatic send_random_row(logic first, logic last);
      logic [VALUE_BITS-1:0] value;
      logic [VALUE_BITS-1:0] threshold;
      value     = pick_value();
      threshold = ($urandom_range(0, 3) == 0) ? value : pick_value();
      send_row(value, threshold, first, last);
   endtask

   initial begin
      int sent;
      int group_len;
      logic [MODE_BITS-1:0] mode;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= CMP_GT;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= 1'b0;
      req_tlast   <= 1'b0;
      no_idle     = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: every compare code, including the two unused ones, against an equal,
      // a smaller and a larger value at the extremes of the range.
      for (int code = 0; code < 8; code++) begin
         write_mode(MODE_BITS'(code));
         send_row(VALUE_MAX, VALUE_MAX, 1'b1, 1'b0);
         send_row(VALUE_MIN, VALUE_MAX, 1'b0, 1'b0);
         send_row(VALUE_MAX, VALUE_MIN, 1'b0, 1'b1);
      end
      // A group end does not clear the totals: this row extends the previous group.
      send_row(32'd5, 32'd0, 1'b0, 1'b1);
      // A single-row group that matches nothing gives a null mean.
      write_mode(CMP_GT);
      send_row(32'd0, 32'd0, 1'b1, 1'b1);

      // Random phases: the first ones walk through every code, later ones pick at random, the last uses not-equal.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         mode = (phase < 8) ? MODE_BITS'(phase) : MODE_BITS'($urandom_range(0, 7));
         if (phase == RANDOM_PHASES - 1) mode = CMP_NE;
         write_mode(mode);
         no_idle = ($urandom_range(0, 3) == 0);
         sent = 0;
         while (sent < ROWS_PER_PHASE) begin
            if ($urandom_range(0, 9) == 0) begin
               // Stray row with arbitrary group flags.
               send_random_row(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               sent++;
            end else begin
               group_len = $urandom_range(1, 8);
               for (int row = 0; row < group_len; row++)
                  send_random_row(row == 0, row == group_len - 1);
               sent += group_len;
            end
         end
         no_idle = 1'b0;
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
